// File: rtl/tss_pkg.sv
// Shared constants for the triangle scanline span unit.
// No dependencies; imported by the top level.
`default_nettype none
package tss_pkg;
  localparam int COORD_W       = 17;  // vertex coordinate width, two's complement
  localparam int ROW_W         = 11;  // scanline number width
  localparam int DIM_W         = 12;  // width/height register and span width
  localparam int FRAC_BITS_DEF = 4;
  localparam int MAX_DIM_DEF   = 2048;
  localparam int IN_DATA_W     = 120; // 6 coordinates + row, padded to bytes
  localparam int OUT_DATA_W    = 24;  // span_start, span_end

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
endpackage
`default_nettype wire

// File: rtl/triangle_scanline_span_calculator_top.sv
// Triangle scanline span unit: one row query in, one span word out.
// Depends on tss_pkg for field widths, register indexes and defaults.
//
// Usage
//   s_axis carries one query word: three vertices (signed fixed point with
//   FRAC_BITS fraction bits) and a row number. m_axis returns one word per
//   query: tuser is row_hit, tdata holds span_start and span_end, clamped to
//   0..image_width. Spans on rows outside the triangle come back as zero.
//   The cfg channel writes image_width (index REG_WIDTH) or image_height
//   (index REG_HEIGHT); cfg_ready_o is always high. Write them only while no
//   query is in flight.
// Pipeline
//   Six arithmetic stages (sort, row rounding and orientation products, edge
//   selection, edge products, numerator sum, clamp compare) feed a restoring
//   divider of one quotient bit per stage, one per span end. One word enters
//   per cycle while the receiver is not stalling a waiting output word.
// Reset and stall
//   Reset clears all stage valid bits and loads width 640, height 480.
//   The whole pipeline advances while the output stage is empty or taken;
//   when the receiver stalls with a word waiting, every stage holds.
`default_nettype none
module triangle_scanline_span_calculator_top #(
  parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF,
  parameter int MAX_DIM   = tss_pkg::MAX_DIM_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, row, pad
  input  wire  [tss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata, low bit up: span_start, span_end
  output logic [tss_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: row_hit
  output logic                              m_axis_tuser,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire                               cfg_addr_i,
  input  wire  [tss_pkg::DIM_W-1:0]         cfg_data_i
);
  import tss_pkg::*;

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;
  localparam int RW   = CW + 2;
  localparam int TA   = ROW_W + 1 + FRAC_BITS;
  localparam int TW   = ((TA > CW + 1) ? TA : CW + 1) + 1;
  localparam int P1W  = CW + DW;
  localparam int P2W  = TW + DW;
  localparam int PWW  = DW + DIM_W + 1;
  localparam int NW   = ((P1W + 1 > P2W) ? P1W + 1 : P2W) + 2;
  localparam int QB   = (MAX_DIM > 4096) ? 12 : $clog2(MAX_DIM);
  localparam int XW   = NW + QB;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // limit to MAX_DIM before use
  assign w_eff = (32'(width_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : width_q;
  assign h_eff = (32'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_q;

  // ---------------- pipeline control ----------------
  logic en;
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic vdiv_q [QB+1];

  assign en            = !vdiv_q[QB] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      for (int j = 0; j <= QB; j++) vdiv_q[j] <= 1'b0;
    end else if (en) begin
      va_q      <= s_axis_tvalid;
      vb_q      <= va_q;
      vc_q      <= vb_q;
      vd_q      <= vc_q;
      ve_q      <= vd_q;
      vdiv_q[0] <= ve_q;
      for (int j = 1; j <= QB; j++) vdiv_q[j] <= vdiv_q[j-1];
    end
  end

  // ---------------- stage A: sort vertices by y ----------------
  logic signed [CW-1:0] ix [3];
  logic signed [CW-1:0] iy [3];
  logic [1:0]           o0, o1, o2;
  logic signed [CW-1:0] vxa_q [3];
  logic signed [CW-1:0] vya_q [3];
  logic [ROW_W-1:0]     rowa_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ix[i] = $signed(s_axis_tdata[2*i*CW +: CW]);
      iy[i] = $signed(s_axis_tdata[(2*i+1)*CW +: CW]);
    end
    if (iy[0] < iy[1]) begin
      if (iy[0] < iy[2]) begin
        o0 = 2'd0;
        if (iy[1] < iy[2]) begin
          o1 = 2'd1; o2 = 2'd2;
        end else begin
          o1 = 2'd2; o2 = 2'd1;
        end
      end else begin
        o0 = 2'd2; o1 = 2'd0; o2 = 2'd1;
      end
    end else begin
      if (iy[1] < iy[2]) begin
        o0 = 2'd1;
        if (iy[0] < iy[2]) begin
          o1 = 2'd0; o2 = 2'd2;
        end else begin
          o1 = 2'd2; o2 = 2'd0;
        end
      end else begin
        o0 = 2'd2; o1 = 2'd1; o2 = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vxa_q[0] <= ix[o0]; vya_q[0] <= iy[o0];
      vxa_q[1] <= ix[o1]; vya_q[1] <= iy[o1];
      vxa_q[2] <= ix[o2]; vya_q[2] <= iy[o2];
      rowa_q   <= s_axis_tdata[6*CW +: ROW_W];
    end
  end

  // ---------------- stage B: row bounds, orientation products ----------------
  logic [DIM_W-1:0]     rnd [3];
  logic signed [RW-1:0] rt  [3];
  logic signed [DW-1:0] dy_a;
  logic [DIM_W-1:0]     rb_q [3];
  logic signed [2*DW-1:0] ma_q, mb_q;
  logic                 dypos_q;
  logic signed [CW-1:0] vxb_q [3];
  logic signed [CW-1:0] vyb_q [3];
  logic [ROW_W-1:0]     rowb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // floor(y + 0.5), clamped to 0..height
      rt[i] = ((RW'(vya_q[i]) <<< 1) + (RW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      if (rt[i] < 0)                            rnd[i] = '0;
      else if (rt[i] > $signed(RW'(h_eff)))     rnd[i] = h_eff;
      else                                      rnd[i] = DIM_W'(rt[i]);
    end
    dy_a = DW'(vya_q[2]) - DW'(vya_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rb_q    <= rnd;
      dypos_q <= dy_a > 0;
      ma_q    <= (2*DW)'(DW'(vxa_q[1]) - DW'(vxa_q[0])) * (2*DW)'(dy_a);
      mb_q    <= (2*DW)'(DW'(vya_q[1]) - DW'(vya_q[0]))
               * (2*DW)'(DW'(vxa_q[2]) - DW'(vxa_q[0]));
      vxb_q   <= vxa_q;
      vyb_q   <= vya_q;
      rowb_q  <= rowa_q;
    end
  end

  // ---------------- stage C: row range and edge selection ----------------
  logic                 left_mid, lower, upper;
  logic [1:0]           sa, sb, ea, eb;
  logic                 hitc_q;
  logic signed [CW-1:0] ax_q [2];
  logic signed [CW-1:0] ay_q [2];
  logic signed [CW-1:0] bx_q [2];
  logic signed [CW-1:0] by_q [2];
  logic [ROW_W-1:0]     rowc_q;

  always_comb begin
    left_mid = dypos_q && (ma_q < mb_q);
    lower    = (DIM_W'(rowb_q) >= rb_q[0]) && (DIM_W'(rowb_q) < rb_q[1]);
    upper    = (DIM_W'(rowb_q) >= rb_q[1]) && (DIM_W'(rowb_q) < rb_q[2]);
    if (lower) begin
      // both edges leave the lowest vertex
      sa = 2'd0; sb = left_mid ? 2'd1 : 2'd2;
      ea = 2'd0; eb = left_mid ? 2'd2 : 2'd1;
    end else begin
      // both edges enter the highest vertex
      sa = left_mid ? 2'd1 : 2'd0; sb = 2'd2;
      ea = left_mid ? 2'd0 : 2'd1; eb = 2'd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hitc_q   <= lower || upper;
      ax_q[0]  <= vxb_q[sa]; ay_q[0] <= vyb_q[sa];
      bx_q[0]  <= vxb_q[sb]; by_q[0] <= vyb_q[sb];
      ax_q[1]  <= vxb_q[ea]; ay_q[1] <= vyb_q[ea];
      bx_q[1]  <= vxb_q[eb]; by_q[1] <= vyb_q[eb];
      rowc_q   <= rowb_q;
    end
  end

  // ---------------- stages D..F and divider, one lane per span end ----------------
  logic hitd_q, hite_q;
  logic hdiv_q [QB+1];
  logic [QB-1:0] quo_out [2];
  logic          neg_out [2];
  logic          big_out [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hitd_q    <= hitc_q;
      hite_q    <= hitd_q;
      hdiv_q[0] <= hite_q;
      for (int j = 1; j <= QB; j++) hdiv_q[j] <= hdiv_q[j-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DW-1:0]  dd, dx;
    logic signed [TW-1:0]  tt;
    logic signed [P1W-1:0] p1_q;
    logic signed [P2W-1:0] p2_q;
    logic signed [PWW-1:0] pw_q;
    logic signed [DW-1:0]  dd_q, dde_q;
    logic signed [NW-1:0]  num_q, lim_q;
    logic [XW-1:0]         rem_q [QB+1];
    logic [XW-1:0]         den_q [QB+1];
    logic [QB-1:0]         quo_q [QB+1];
    logic                  neg_q [QB+1];
    logic                  big_q [QB+1];

    always_comb begin
      dd = DW'(by_q[l]) - DW'(ay_q[l]);
      dx = DW'(bx_q[l]) - DW'(ax_q[l]);
      // (2*row + 1) * s - 2*ay : row centre against edge start, doubled
      tt = ($signed(TW'({rowc_q, 1'b1})) <<< FRAC_BITS) - (TW'(ay_q[l]) <<< 1);
    end

    // stage D: edge products
    always_ff @(posedge clk_i) begin
      if (en) begin
        p1_q <= P1W'(ax_q[l]) * P1W'(dd);
        p2_q <= P2W'(tt) * P2W'(dx);
        pw_q <= PWW'(dd) * $signed(PWW'(w_eff));
        dd_q <= dd;
      end
    end

    // stage E: numerator and clamp limit, both doubled
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q <= (NW'(p1_q) <<< 1) + NW'(p2_q) + (NW'(dd_q) <<< FRAC_BITS);
        lim_q <= NW'(pw_q) <<< (FRAC_BITS + 1);
        dde_q <= dd_q;
      end
    end

    // stage F: clamp flags, load divider
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[0] <= num_q < 0;
        big_q[0] <= num_q >= lim_q;
        rem_q[0] <= XW'(unsigned'(num_q));
        den_q[0] <= XW'(unsigned'(NW'(dde_q) <<< (FRAC_BITS + 1)));
        quo_q[0] <= '0;
      end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= QB; j++) begin : g_div
      logic [XW-1:0] trial;
      logic          take;
      assign trial = den_q[j-1] << (QB - j);
      assign take  = rem_q[j-1] >= trial;
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[j] <= take ? rem_q[j-1] - trial : rem_q[j-1];
          quo_q[j] <= quo_q[j-1] | (take ? (QB'(1) << (QB - j)) : '0);
          den_q[j] <= den_q[j-1];
          neg_q[j] <= neg_q[j-1];
          big_q[j] <= big_q[j-1];
        end
      end
    end

    assign quo_out[l] = quo_q[QB];
    assign neg_out[l] = neg_q[QB];
    assign big_out[l] = big_q[QB];
  end

  // ---------------- output word ----------------
  logic [DIM_W-1:0] span [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!hdiv_q[QB] || neg_out[l]) span[l] = '0;
      else if (big_out[l])           span[l] = w_eff;
      else                           span[l] = DIM_W'(quo_out[l]);
    end
  end

  assign m_axis_tvalid = vdiv_q[QB];
  assign m_axis_tuser  = hdiv_q[QB];
  assign m_axis_tdata  = {span[1], span[0]};

  // ---------------- assertions ----------------
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("missed row gives non-zero span");

  a_span_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DIM_W-1:0] <= w_eff)
                   && (m_axis_tdata[2*DIM_W-1:DIM_W] <= w_eff))
    else $error("span end beyond image width");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> va_q)
    else $error("accepted word not captured in first stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdiv_q[QB] && !m_axis_tready |=> $stable(va_q) && $stable(ve_q))
    else $error("pipeline moved during output stall");
endmodule
`default_nettype wire
